// File: rtl/core/melc_pkg.sv
// ----------------------------------------------------------------------------
// melc_pkg
// Shared widths, control state codes, compare codes, register indexes and
// reciprocal constants for the monthly energy limit controller.
// ----------------------------------------------------------------------------
`default_nettype none

package melc_pkg;

    localparam int GROUPS = 8;
    localparam int ROUNDS = 8;

    localparam int GRP_W    = 3;
    localparam int ENERGY_W = 34;
    localparam int LIMIT_W  = 35;
    localparam int PCT_W    = 7;
    localparam int RND_W    = 8;
    localparam int ST_W     = 3;
    localparam int CMP_W    = 2;
    localparam int PROD_W   = 41;
    localparam int PADDR_W  = 3;
    localparam int DATA_W   = 32;

    localparam logic [RND_W-1:0] ROUND_MASK = RND_W'((1 << ROUNDS) - 1);

    localparam logic [ST_W-1:0] ST_OFF   = 3'd0;
    localparam logic [ST_W-1:0] ST_CTRL  = 3'd1;
    localparam logic [ST_W-1:0] ST_ALARM = 3'd2;
    localparam logic [ST_W-1:0] ST_PREP  = 3'd3;
    localparam logic [ST_W-1:0] ST_TRIP  = 3'd4;

    localparam logic [CMP_W-1:0] CMP_WITHIN = 2'd0;
    localparam logic [CMP_W-1:0] CMP_ALARM  = 2'd1;
    localparam logic [CMP_W-1:0] CMP_LIMIT  = 2'd2;

    localparam logic REG_FLOAT_PERCENT = 1'b0;
    localparam logic REG_FLOAT_DOWN    = 1'b1;

    // floor(2^27 / 100) and floor(2^34 / 100)
    localparam logic [20:0] RECIP_HI = 21'd1342177;
    localparam logic [27:0] RECIP_LO = 28'd171798691;

    typedef struct packed {
        logic [GRP_W-1:0]    group;
        logic                enabled;
        logic                keep;
        logic [ENERGY_W-1:0] energy;
        logic [ENERGY_W-1:0] base;
        logic [PCT_W-1:0]    apct;
        logic [RND_W-1:0]    rcfg;
        logic                alarm_hit;
    } item_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] lim;
        logic [RND_W-1:0]   rounds;
        logic [ST_W-1:0]    state;
    } grp_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/melc_ram.sv
// ----------------------------------------------------------------------------
// melc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module melc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/monthly_energy_limit_control.sv
// ----------------------------------------------------------------------------
// monthly_energy_limit_control
// Per-group monthly energy limit controller: floated limit, alarm threshold
// and off/control/alarm/trip-prepare/tripped state for each group.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side does not
// stall, and returns one result per item in order. The
// floated limit is built by a seven-stage pipeline (product, two reciprocal
// multiply and correct steps for the divide by 100, saturation); the group
// state lives in one RAM that is read one stage before the update and written
// back as the result leaves, with the last write forwarded so that items for
// the same group may follow each other in consecutive cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module monthly_energy_limit_control (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [melc_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [melc_pkg::DATA_W-1:0]       pwdata,
    output logic      [melc_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [melc_pkg::GRP_W-1:0]        group,
    input  wire logic                              ctrl_enabled,
    input  wire logic                              keep_power,
    input  wire logic [melc_pkg::ENERGY_W-1:0]     energy_kwh,
    input  wire logic [melc_pkg::ENERGY_W-1:0]     limit_kwh,
    input  wire logic [melc_pkg::PCT_W-1:0]        alarm_percent,
    input  wire logic [melc_pkg::RND_W-1:0]        rounds_config,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [melc_pkg::GRP_W-1:0]        group_out,
    output logic      [melc_pkg::ST_W-1:0]         ctrl_state,
    output logic      [melc_pkg::RND_W-1:0]        rounds_tripped,
    output logic      [melc_pkg::CMP_W-1:0]        compare_result,
    output logic                                   alarm_event,
    output logic                                   trip_event,
    output logic      [melc_pkg::RND_W-1:0]        event_rounds,
    output logic      [melc_pkg::ENERGY_W-1:0]     event_energy_kwh,
    output logic      [melc_pkg::LIMIT_W-1:0]      event_limit_kwh,
    output logic                                   trip_counted
);

    localparam int ENTRY_W = $bits(melc_pkg::grp_entry_t);

    // ---------------- configuration ----------------
    logic [melc_pkg::PCT_W-1:0] fp_reg;
    logic                       fd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg <= '0;
            fd_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                melc_pkg::REG_FLOAT_PERCENT: fp_reg <= pwdata[melc_pkg::PCT_W-1:0];
                melc_pkg::REG_FLOAT_DOWN:    fd_reg <= pwdata[0];
                default:                     fp_reg <= fp_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            melc_pkg::REG_FLOAT_PERCENT:
                prdata = {{(melc_pkg::DATA_W-melc_pkg::PCT_W){1'b0}}, fp_reg};
            melc_pkg::REG_FLOAT_DOWN:
                prdata = {{(melc_pkg::DATA_W-1){1'b0}}, fd_reg};
            default:
                prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------- pipeline control ----------------
    logic       advance;
    logic [6:0] vld_reg;
    logic       out_valid_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[5:0], in_valid};
            out_valid_reg <= vld_reg[6];
        end
    end

    // ---------------- stage datapath ----------------
    melc_pkg::item_t s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;
    melc_pkg::item_t s5_item_reg, s6_item_reg, s7_item_reg;
    melc_pkg::item_t in_item_next, s3_item_next;

    logic [melc_pkg::PROD_W-1:0] s2_p_reg, s2_a_reg, s2_e1_reg;
    logic [melc_pkg::PROD_W-1:0] p_next, a_next, e1_next;

    logic [20:0] ph_next;
    logic [41:0] qa_prod_next;
    logic [14:0] s3_qa_reg;
    logic [20:0] s3_ph_reg;
    logic [19:0] s3_pl_reg;

    logic [20:0] qa100_next, rdiff_next;
    logic        hi_next;
    logic [14:0] qh_next;
    logic [6:0]  rh_next;
    logic [14:0] s4_qh_reg;
    logic [6:0]  s4_rh_reg;
    logic [19:0] s4_pl_reg;

    logic [26:0] nxt_next;
    logic [54:0] ql_prod_next;
    logic [19:0] s5_qla_reg;
    logic [26:0] s5_nxt_reg;
    logic [14:0] s5_qh_reg;

    logic [26:0] ql100_next, rdiff2_next;
    logic        hi2_next;
    logic [19:0] ql_next;
    logic [melc_pkg::LIMIT_W-1:0] s6_delta_reg;

    logic [melc_pkg::LIMIT_W:0]   sum_next;
    logic [melc_pkg::LIMIT_W-1:0] lim_next;
    logic [melc_pkg::LIMIT_W-1:0] s7_lim_reg;

    always_comb
    begin
        in_item_next.group     = group;
        in_item_next.enabled   = ctrl_enabled;
        in_item_next.keep      = keep_power;
        in_item_next.energy    = energy_kwh;
        in_item_next.base      = limit_kwh;
        in_item_next.apct      = alarm_percent;
        in_item_next.rcfg      = rounds_config;
        in_item_next.alarm_hit = 1'b0;
    end

    assign p_next  = melc_pkg::PROD_W'(s1_item_reg.base) * melc_pkg::PROD_W'(fp_reg);
    assign a_next  = melc_pkg::PROD_W'(s1_item_reg.base) * melc_pkg::PROD_W'(s1_item_reg.apct);
    assign e1_next = (melc_pkg::PROD_W'(s1_item_reg.energy) + melc_pkg::PROD_W'(1))
                     * melc_pkg::PROD_W'(100);

    assign ph_next      = s2_p_reg[40:20];
    assign qa_prod_next = 42'(ph_next) * 42'(melc_pkg::RECIP_HI);

    always_comb
    begin
        s3_item_next           = s2_item_reg;
        s3_item_next.alarm_hit = (s2_a_reg < s2_e1_reg);
    end

    assign qa100_next = 21'(s3_qa_reg) * 21'd100;
    assign rdiff_next = s3_ph_reg - qa100_next;
    assign hi_next    = (rdiff_next[7:0] >= 8'd100);
    assign qh_next    = hi_next ? (s3_qa_reg + 15'd1) : s3_qa_reg;
    assign rh_next    = hi_next ? 7'(rdiff_next[7:0] - 8'd100) : rdiff_next[6:0];

    assign nxt_next     = {s4_rh_reg, s4_pl_reg};
    assign ql_prod_next = 55'(nxt_next) * 55'(melc_pkg::RECIP_LO);

    assign ql100_next  = 27'(s5_qla_reg) * 27'd100;
    assign rdiff2_next = s5_nxt_reg - ql100_next;
    assign hi2_next    = (rdiff2_next[7:0] >= 8'd100);
    assign ql_next     = hi2_next ? (s5_qla_reg + 20'd1) : s5_qla_reg;

    always_comb
    begin
        sum_next = (melc_pkg::LIMIT_W+1)'(s6_item_reg.base)
                   + (melc_pkg::LIMIT_W+1)'(s6_delta_reg);
        if (fd_reg)
        begin
            if (s6_delta_reg > melc_pkg::LIMIT_W'(s6_item_reg.base))
            begin
                lim_next = '0;
            end
            else
            begin
                lim_next = melc_pkg::LIMIT_W'(s6_item_reg.base) - s6_delta_reg;
            end
        end
        else if (sum_next[melc_pkg::LIMIT_W])
        begin
            lim_next = '1;
        end
        else
        begin
            lim_next = sum_next[melc_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg  <= in_item_next;

            s2_item_reg  <= s1_item_reg;
            s2_p_reg     <= p_next;
            s2_a_reg     <= a_next;
            s2_e1_reg    <= e1_next;

            s3_item_reg  <= s3_item_next;
            s3_qa_reg    <= qa_prod_next[41:27];
            s3_ph_reg    <= ph_next;
            s3_pl_reg    <= s2_p_reg[19:0];

            s4_item_reg  <= s3_item_reg;
            s4_qh_reg    <= qh_next;
            s4_rh_reg    <= rh_next;
            s4_pl_reg    <= s3_pl_reg;

            s5_item_reg  <= s4_item_reg;
            s5_qla_reg   <= ql_prod_next[53:34];
            s5_nxt_reg   <= nxt_next;
            s5_qh_reg    <= s4_qh_reg;

            s6_item_reg  <= s5_item_reg;
            s6_delta_reg <= {s5_qh_reg, ql_next};

            s7_item_reg  <= s6_item_reg;
            s7_lim_reg   <= lim_next;
        end
    end

    // ---------------- group state memory ----------------
    logic [ENTRY_W-1:0]           ram_rdata;
    logic                         ram_we;
    melc_pkg::grp_entry_t         wr_entry_next;
    melc_pkg::grp_entry_t         cur_entry;
    logic [melc_pkg::GROUPS-1:0]  vbit_reg;
    logic                         fwd_vld_reg;
    logic [melc_pkg::GRP_W-1:0]   fwd_group_reg;
    melc_pkg::grp_entry_t         fwd_entry_reg;
    logic                         in_range;

    assign in_range = ((melc_pkg::GRP_W+1)'(s7_item_reg.group)
                       < (melc_pkg::GRP_W+1)'(melc_pkg::GROUPS));
    assign ram_we   = advance && vld_reg[6] && in_range;

    melc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (melc_pkg::GROUPS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s7_item_reg.group),
        .wdata (wr_entry_next),
        .re    (advance),
        .raddr (s6_item_reg.group),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbit_reg    <= '0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                vbit_reg[s7_item_reg.group] <= 1'b1;
            end
            if (advance)
            begin
                fwd_vld_reg <= ram_we;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_group_reg <= s7_item_reg.group;
            fwd_entry_reg <= wr_entry_next;
        end
    end

    always_comb
    begin
        if (fwd_vld_reg && (fwd_group_reg == s7_item_reg.group))
        begin
            cur_entry = fwd_entry_reg;
        end
        else if (vbit_reg[s7_item_reg.group])
        begin
            cur_entry = melc_pkg::grp_entry_t'(ram_rdata);
        end
        else
        begin
            cur_entry = '0;
        end
    end

    // ---------------- state update ----------------
    logic [melc_pkg::CMP_W-1:0]    cmp_calc;
    logic [melc_pkg::ST_W-1:0]     st_start;
    logic [melc_pkg::ST_W-1:0]     st_next;
    logic [melc_pkg::RND_W-1:0]    rd_next;
    logic [melc_pkg::RND_W-1:0]    mask_next;
    logic [melc_pkg::LIMIT_W-1:0]  lim_store_next;
    logic [melc_pkg::CMP_W-1:0]    cmp_next;
    logic                          alarm_next, trip_next, counted_next;
    logic [melc_pkg::RND_W-1:0]    evr_next;
    logic [melc_pkg::ENERGY_W-1:0] eve_next;
    logic [melc_pkg::LIMIT_W-1:0]  evl_next;

    always_comb
    begin
        if (melc_pkg::LIMIT_W'(s7_item_reg.energy) >= s7_lim_reg)
        begin
            cmp_calc = melc_pkg::CMP_LIMIT;
        end
        else if (s7_item_reg.alarm_hit)
        begin
            cmp_calc = melc_pkg::CMP_ALARM;
        end
        else
        begin
            cmp_calc = melc_pkg::CMP_WITHIN;
        end
    end

    always_comb
    begin
        st_next        = cur_entry.state;
        rd_next        = cur_entry.rounds;
        lim_store_next = cur_entry.lim;
        cmp_next       = melc_pkg::CMP_WITHIN;
        alarm_next     = 1'b0;
        trip_next      = 1'b0;
        counted_next   = 1'b0;
        evr_next       = '0;
        eve_next       = '0;
        evl_next       = '0;
        mask_next      = s7_item_reg.rcfg & melc_pkg::ROUND_MASK;
        st_start       = cur_entry.state;

        if (!in_range || !s7_item_reg.enabled)
        begin
            st_next = melc_pkg::ST_OFF;
            rd_next = '0;
        end
        else
        begin
            if (s7_item_reg.keep)
            begin
                st_start = melc_pkg::ST_OFF;
                rd_next  = '0;
            end
            case (st_start)
                melc_pkg::ST_OFF:
                begin
                    st_next = melc_pkg::ST_CTRL;
                end
                melc_pkg::ST_CTRL:
                begin
                    cmp_next       = cmp_calc;
                    lim_store_next = s7_lim_reg;
                    st_next        = melc_pkg::ST_CTRL;
                    if (cmp_calc == melc_pkg::CMP_ALARM)
                    begin
                        alarm_next = 1'b1;
                        evr_next   = s7_item_reg.rcfg;
                        eve_next   = s7_item_reg.energy;
                        evl_next   = s7_lim_reg;
                        st_next    = melc_pkg::ST_ALARM;
                    end
                    else if (cmp_calc == melc_pkg::CMP_LIMIT)
                    begin
                        st_next = melc_pkg::ST_PREP;
                    end
                end
                melc_pkg::ST_ALARM:
                begin
                    cmp_next       = cmp_calc;
                    lim_store_next = s7_lim_reg;
                    st_next        = melc_pkg::ST_ALARM;
                    if (cmp_calc == melc_pkg::CMP_WITHIN)
                    begin
                        st_next = melc_pkg::ST_CTRL;
                    end
                    else if (cmp_calc == melc_pkg::CMP_LIMIT)
                    begin
                        st_next = melc_pkg::ST_PREP;
                    end
                end
                melc_pkg::ST_PREP:
                begin
                    if (mask_next != '0)
                    begin
                        rd_next   = mask_next;
                        trip_next = 1'b1;
                        evr_next  = mask_next;
                        eve_next  = s7_item_reg.energy;
                        evl_next  = cur_entry.lim;
                    end
                    st_next      = melc_pkg::ST_TRIP;
                    counted_next = 1'b1;
                end
                melc_pkg::ST_TRIP:
                begin
                    cmp_next       = cmp_calc;
                    lim_store_next = s7_lim_reg;
                    st_next        = melc_pkg::ST_TRIP;
                    if (cmp_calc != melc_pkg::CMP_LIMIT)
                    begin
                        st_next = melc_pkg::ST_CTRL;
                        rd_next = '0;
                    end
                end
                default:
                begin
                    st_next = melc_pkg::ST_OFF;
                    rd_next = '0;
                end
            endcase
        end

        wr_entry_next.state  = st_next;
        wr_entry_next.rounds = rd_next;
        wr_entry_next.lim    = lim_store_next;
    end

    // ---------------- output register ----------------
    logic [melc_pkg::GRP_W-1:0]    group_out_reg;
    logic [melc_pkg::ST_W-1:0]     ctrl_state_reg;
    logic [melc_pkg::RND_W-1:0]    rounds_reg;
    logic [melc_pkg::CMP_W-1:0]    cmp_reg;
    logic                          alarm_reg, trip_reg, counted_reg;
    logic [melc_pkg::RND_W-1:0]    evr_reg;
    logic [melc_pkg::ENERGY_W-1:0] eve_reg;
    logic [melc_pkg::LIMIT_W-1:0]  evl_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            group_out_reg  <= s7_item_reg.group;
            ctrl_state_reg <= st_next;
            rounds_reg     <= rd_next;
            cmp_reg        <= cmp_next;
            alarm_reg      <= alarm_next;
            trip_reg       <= trip_next;
            counted_reg    <= counted_next;
            evr_reg        <= evr_next;
            eve_reg        <= eve_next;
            evl_reg        <= evl_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign group_out        = group_out_reg;
    assign ctrl_state       = ctrl_state_reg;
    assign rounds_tripped   = rounds_reg;
    assign compare_result   = cmp_reg;
    assign alarm_event      = alarm_reg;
    assign trip_event       = trip_reg;
    assign event_rounds     = evr_reg;
    assign event_energy_kwh = eve_reg;
    assign event_limit_kwh  = evl_reg;
    assign trip_counted     = counted_reg;

    // ---------------- assertions ----------------
    a_event_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(alarm_reg && trip_reg))
        else $error("alarm and trip event in one item");

    a_event_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !alarm_reg && !trip_reg)
        |-> (evr_reg == '0 && eve_reg == '0 && evl_reg == '0))
        else $error("event data without event");

    a_prep_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ctrl_state_reg == melc_pkg::ST_PREP)
        |-> (cmp_reg == melc_pkg::CMP_LIMIT))
        else $error("trip prepare entered without limit reached");

    a_trip_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && trip_reg)
        |-> (counted_reg && ctrl_state_reg == melc_pkg::ST_TRIP))
        else $error("trip event outside tripped state");

    a_wb_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> vbit_reg[$past(s7_item_reg.group)])
        else $error("written group entry not marked valid");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for monthly_energy_limit_control. Drives input items
// through a valid/ready channel and sets the limit float through the APB
// port. A predictor tracks each group's control state, held rounds and
// limit in force, and queues one expected result per accepted item. Results
// are compared field by field in order. The stimulus covers directed state
// walks first, then random readings placed around the alarm threshold and
// the floated limit under several float settings. Both channel sides idle
// and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import melc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 240;
    localparam int PRINT_LIMIT = 50;
    localparam logic [ENERGY_W-1:0] E_MAX = '1;
    localparam logic [LIMIT_W-1:0]  L_MAX = '1;

    typedef struct packed {
        logic [GRP_W-1:0]    grp;
        logic                en;
        logic                keep;
        logic [ENERGY_W-1:0] energy;
        logic [ENERGY_W-1:0] base;
        logic [PCT_W-1:0]    apct;
        logic [RND_W-1:0]    rcfg;
    } reading_t;

    typedef struct packed {
        logic [GRP_W-1:0]    grp;
        logic [ST_W-1:0]     state;
        logic [RND_W-1:0]    rounds;
        logic [CMP_W-1:0]    cmp;
        logic                alarm;
        logic                trip;
        logic [RND_W-1:0]    ev_rounds;
        logic [ENERGY_W-1:0] ev_energy;
        logic [LIMIT_W-1:0]  ev_limit;
        logic                counted;
    } verdict_t;

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [GRP_W-1:0]    group         = '0;
    logic                ctrl_enabled  = 1'b0;
    logic                keep_power    = 1'b0;
    logic [ENERGY_W-1:0] energy_kwh    = '0;
    logic [ENERGY_W-1:0] limit_kwh     = '0;
    logic [PCT_W-1:0]    alarm_percent = '0;
    logic [RND_W-1:0]    rounds_config = '0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [GRP_W-1:0]    group_out;
    logic [ST_W-1:0]     ctrl_state;
    logic [RND_W-1:0]    rounds_tripped;
    logic [CMP_W-1:0]    compare_result;
    logic                alarm_event;
    logic                trip_event;
    logic [RND_W-1:0]    event_rounds;
    logic [ENERGY_W-1:0] event_energy_kwh;
    logic [LIMIT_W-1:0]  event_limit_kwh;
    logic                trip_counted;

    // predictor copy of the registers and the per-group state
    logic [PCT_W-1:0]    cfg_float_pct  = '0;
    logic                cfg_float_down = 1'b0;
    logic [ST_W-1:0]     grp_state  [GROUPS] = '{default: '0};
    logic [RND_W-1:0]    grp_rounds [GROUPS] = '{default: '0};
    logic [LIMIT_W-1:0]  grp_limit  [GROUPS] = '{default: '0};

    verdict_t verdicts_due[$];

    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int alarms_seen   = 0;
    int trips_seen    = 0;
    int settings_used = 0;
    int burst_left    = 0;

    logic [5:0] rx_count = '0;
    int         rx_mode  = 0;

    monthly_energy_limit_control u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .group            (group),
        .ctrl_enabled     (ctrl_enabled),
        .keep_power       (keep_power),
        .energy_kwh       (energy_kwh),
        .limit_kwh        (limit_kwh),
        .alarm_percent    (alarm_percent),
        .rounds_config    (rounds_config),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .group_out        (group_out),
        .ctrl_state       (ctrl_state),
        .rounds_tripped   (rounds_tripped),
        .compare_result   (compare_result),
        .alarm_event      (alarm_event),
        .trip_event       (trip_event),
        .event_rounds     (event_rounds),
        .event_energy_kwh (event_energy_kwh),
        .event_limit_kwh  (event_limit_kwh),
        .trip_counted     (trip_counted)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("tb: mismatch in %s: got 0x%0h, want 0x%0h", what, got, want);
        mismatches++;
    endtask

    function automatic logic [LIMIT_W-1:0] floated_limit(input logic [ENERGY_W-1:0] base);
        logic [63:0] delta;
        logic [63:0] lim;
        delta = (64'(base) * 64'(cfg_float_pct)) / 64'd100;
        if (!cfg_float_down)
        begin
            lim = 64'(base) + delta;
            if (lim > 64'(L_MAX))
                lim = 64'(L_MAX);
        end
        else
        begin
            lim = (delta > 64'(base)) ? 64'd0 : 64'(base) - delta;
        end
        return lim[LIMIT_W-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] judge_energy(input reading_t r);
        logic [LIMIT_W-1:0] lim;
        logic [63:0]        thr;
        lim = floated_limit(r.base);
        grp_limit[r.grp] = lim;
        thr = (64'(r.base) * 64'(r.apct)) / 64'd100;
        if (64'(r.energy) >= 64'(lim))
            return CMP_LIMIT;
        if (64'(r.energy) >= thr)
            return CMP_ALARM;
        return CMP_WITHIN;
    endfunction

    function automatic verdict_t evaluate_reading(input reading_t r);
        verdict_t         v;
        logic [ST_W-1:0]  st;
        logic [RND_W-1:0] rd;
        logic [RND_W-1:0] mask;
        v = '0;
        v.grp = r.grp;
        if (int'(r.grp) < GROUPS)
        begin
            st = grp_state[r.grp];
            rd = grp_rounds[r.grp];
            if (!r.en)
            begin
                st = ST_OFF;
                rd = '0;
            end
            else
            begin
                if (r.keep)
                begin
                    st = ST_OFF;
                    rd = '0;
                end
                case (st)
                    ST_OFF:
                    begin
                        st = ST_CTRL;
                    end
                    ST_CTRL:
                    begin
                        v.cmp = judge_energy(r);
                        if (v.cmp == CMP_ALARM)
                        begin
                            v.alarm     = 1'b1;
                            v.ev_rounds = r.rcfg;
                            v.ev_energy = r.energy;
                            v.ev_limit  = grp_limit[r.grp];
                            st = ST_ALARM;
                        end
                        else if (v.cmp == CMP_LIMIT)
                        begin
                            st = ST_PREP;
                        end
                    end
                    ST_ALARM:
                    begin
                        v.cmp = judge_energy(r);
                        if (v.cmp == CMP_WITHIN)
                            st = ST_CTRL;
                        else if (v.cmp == CMP_LIMIT)
                            st = ST_PREP;
                    end
                    ST_PREP:
                    begin
                        mask = r.rcfg & ROUND_MASK;
                        if (mask != '0)
                        begin
                            rd          = mask;
                            v.trip      = 1'b1;
                            v.ev_rounds = mask;
                            v.ev_energy = r.energy;
                            v.ev_limit  = grp_limit[r.grp];
                        end
                        st = ST_TRIP;
                        v.counted = 1'b1;
                    end
                    ST_TRIP:
                    begin
                        v.cmp = judge_energy(r);
                        if (v.cmp != CMP_LIMIT)
                        begin
                            st = ST_CTRL;
                            rd = '0;
                        end
                    end
                    default:
                    begin
                        st = ST_OFF;
                        rd = '0;
                    end
                endcase
            end
            grp_state[r.grp]  = st;
            grp_rounds[r.grp] = rd;
            v.state  = st;
            v.rounds = rd;
        end
        return v;
    endfunction

    function automatic reading_t reading(input int g, input bit en, input bit keep,
                                         input logic [ENERGY_W-1:0] energy,
                                         input logic [ENERGY_W-1:0] base,
                                         input int apct, input logic [RND_W-1:0] rcfg);
        reading_t r;
        r.grp    = GRP_W'(g);
        r.en     = en;
        r.keep   = keep;
        r.energy = energy;
        r.base   = base;
        r.apct   = PCT_W'(apct);
        r.rcfg   = rcfg;
        return r;
    endfunction

    // place the energy around the alarm threshold and the floated limit
    function automatic reading_t random_reading();
        reading_t            r;
        logic [ENERGY_W-1:0] raw;
        logic [63:0]         lim;
        logic [63:0]         thr;
        logic [63:0]         e;
        logic [63:0]         rnd;
        r.grp  = GRP_W'($urandom_range(0, GROUPS - 1));
        r.en   = ($urandom_range(0, 99) >= 6);
        r.keep = ($urandom_range(0, 99) < 4);
        if ($urandom_range(0, 7) == 0)
            r.apct = ($urandom_range(0, 1) == 1) ? PCT_W'(99) : '0;
        else
            r.apct = PCT_W'($urandom_range(0, 99));
        r.rcfg = ($urandom_range(0, 5) == 0) ? '0 : RND_W'($urandom());
        raw = ENERGY_W'({$urandom(), $urandom()});
        case ($urandom_range(0, 15))
            0:       r.base = E_MAX;
            1:       r.base = '0;
            default: r.base = raw >> $urandom_range(0, 33);
        endcase
        lim = 64'(floated_limit(r.base));
        thr = (64'(r.base) * 64'(r.apct)) / 64'd100;
        rnd = {$urandom(), $urandom()};
        case ($urandom_range(0, 15))
            0, 1, 2:     e = (thr == 0) ? 64'd0 : rnd % thr;
            3:           e = thr;
            4:           e = (thr == 0) ? 64'd0 : thr - 1;
            5, 6, 7, 8:  e = (lim > thr) ? thr + rnd % (lim - thr) : thr;
            9:           e = (lim == 0) ? 64'd0 : lim - 1;
            10:          e = lim;
            11, 12, 13:  e = (lim >= 64'(E_MAX)) ? 64'(E_MAX)
                                                  : lim + rnd % (64'(E_MAX) - lim + 1);
            default:     e = 64'(ENERGY_W'(rnd));
        endcase
        if (e > 64'(E_MAX))
            e = 64'(E_MAX);
        r.energy = e[ENERGY_W-1:0];
        return r;
    endfunction

    task automatic send_reading(input reading_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        group         <= r.grp;
        ctrl_enabled  <= r.en;
        keep_power    <= r.keep;
        energy_kwh    <= r.energy;
        limit_kwh     <= r.base;
        alarm_percent <= r.apct;
        rounds_config <= r.rcfg;
        do @(posedge clk); while (!in_ready);
        verdicts_due.push_back(evaluate_reading(r));
        items_sent++;
    endtask

    task automatic await_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            report_mismatch("register readback", 64'(prdata), 64'(want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_float(input int pct, input bit down);
        apb_write({REG_FLOAT_PERCENT, 2'b00}, DATA_W'(pct));
        apb_write({REG_FLOAT_DOWN, 2'b00}, DATA_W'(down));
        cfg_float_pct  = PCT_W'(pct);
        cfg_float_down = down;
        apb_read_check({REG_FLOAT_PERCENT, 2'b00}, DATA_W'(pct));
        apb_read_check({REG_FLOAT_DOWN, 2'b00}, DATA_W'(down));
        settings_used++;
    endtask

    task automatic test_power_up();
        send_reading(reading(0, 1, 0, '0, '0, 0, '0));
        send_reading(reading(7, 1, 0, E_MAX, E_MAX, 99, 8'hFF));
    endtask

    task automatic test_alarm_and_trip();
        send_reading(reading(7, 1, 0, 34'd500, 34'd1000, 50, 8'hFF));
        send_reading(reading(7, 1, 0, 34'd999, 34'd1000, 50, 8'h3C));
        send_reading(reading(7, 1, 0, 34'd1000, 34'd1000, 50, 8'h00));
        send_reading(reading(7, 1, 0, 34'd1000, 34'd1000, 50, 8'hA5));
        send_reading(reading(7, 1, 0, E_MAX, 34'd1000, 0, 8'h00));
        send_reading(reading(7, 1, 0, '0, 34'd1000, 0, 8'hFF));
    endtask

    task automatic test_range_extremes();
        send_reading(reading(0, 1, 0, '0, E_MAX, 99, 8'hFF));
        send_reading(reading(0, 1, 0, E_MAX, E_MAX, 99, 8'h00));
        send_reading(reading(0, 1, 0, E_MAX, E_MAX, 99, 8'h00));
        send_reading(reading(0, 1, 0, '0, '0, 0, 8'h00));
        send_reading(reading(0, 1, 0, 34'd5, 34'd10, 99, 8'h81));
    endtask

    task automatic test_overrides();
        send_reading(reading(3, 0, 0, 34'd100, 34'd100, 10, 8'hFF));
        send_reading(reading(3, 1, 1, 34'd100, 34'd100, 10, 8'hFF));
        send_reading(reading(3, 1, 0, 34'd100, 34'd100, 10, 8'hFF));
        send_reading(reading(3, 1, 1, 34'd100, 34'd100, 10, 8'hFF));
        send_reading(reading(3, 1, 0, 34'd100, 34'd100, 10, 8'hFF));
        send_reading(reading(3, 1, 0, 34'd100, 34'd100, 10, 8'h0F));
        send_reading(reading(3, 0, 1, E_MAX, 34'd100, 10, 8'hFF));
        send_reading(reading(3, 1, 1, E_MAX, E_MAX, 99, 8'hFF));
    endtask

    task automatic run_random_phase(input int pct, input bit down);
        await_results();
        set_float(pct, down);
        repeat (PHASE_ITEMS) send_reading(random_reading());
    endtask

    task automatic test_float_settings();
        run_random_phase(79, 1'b0);
        run_random_phase(0, 1'b1);
        run_random_phase(79, 1'b1);
        run_random_phase($urandom_range(1, 78), 1'b0);
        run_random_phase($urandom_range(1, 78), 1'b1);
        run_random_phase(1, 1'b0);
        run_random_phase(0, 1'b0);
    endtask

    always @(posedge clk)
    begin : ready_pattern
        rx_count <= rx_count + 6'd1;
        if (rx_count == '0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= (rx_count % 3 == 0);
            default: out_ready <= (rx_count[2:0] >= 3'd6);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (verdicts_due.size() == 0)
            begin
                report_mismatch("result with none pending", 64'(group_out), 64'd0);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (want.alarm)
                    alarms_seen++;
                if (want.trip)
                    trips_seen++;
                if (group_out !== want.grp)
                    report_mismatch("group_out", 64'(group_out), 64'(want.grp));
                if (ctrl_state !== want.state)
                    report_mismatch("ctrl_state", 64'(ctrl_state), 64'(want.state));
                if (rounds_tripped !== want.rounds)
                    report_mismatch("rounds_tripped", 64'(rounds_tripped), 64'(want.rounds));
                if (compare_result !== want.cmp)
                    report_mismatch("compare_result", 64'(compare_result), 64'(want.cmp));
                if (alarm_event !== want.alarm)
                    report_mismatch("alarm_event", 64'(alarm_event), 64'(want.alarm));
                if (trip_event !== want.trip)
                    report_mismatch("trip_event", 64'(trip_event), 64'(want.trip));
                if (event_rounds !== want.ev_rounds)
                    report_mismatch("event_rounds", 64'(event_rounds), 64'(want.ev_rounds));
                if (event_energy_kwh !== want.ev_energy)
                    report_mismatch("event_energy_kwh", 64'(event_energy_kwh),
                                    64'(want.ev_energy));
                if (event_limit_kwh !== want.ev_limit)
                    report_mismatch("event_limit_kwh", 64'(event_limit_kwh),
                                    64'(want.ev_limit));
                if (trip_counted !== want.counted)
                    report_mismatch("trip_counted", 64'(trip_counted), 64'(want.counted));
            end
        end
    end

    initial
    begin : main
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_up();
        test_alarm_and_trip();
        test_range_extremes();
        test_overrides();
        test_float_settings();
        await_results();
        repeat (16) @(posedge clk);
        $display("tb: %0d items in, %0d results checked, %0d float settings applied",
                 items_sent, results_seen, settings_used);
        $display("tb: %0d alarm events and %0d trip events predicted, %0d mismatches",
                 alarms_seen, trips_seen, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
